[rtl/fud_pkg.sv]
// Shared types, character codes and the escape digit helper for the form decoder.
// Depends on nothing; every other file of the decoder imports it.
package fud_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CASE_MASK    = 8'hDF;
   localparam logic [7:0] LETTER_BASE  = 8'd10;

   // Bit positions in the result mask of one queued item.
   localparam int RES_PRIMARY    = 0;
   localparam int RES_NAME_CLOSE = 1;
   localparam int RES_VALUE_CLOSE = 2;
   localparam int RES_COUNT      = 3;

   localparam logic PART_NAME  = 1'b0;
   localparam logic PART_VALUE = 1'b1;

   typedef enum logic [2:0] {
      ESC_NONE = 3'b001,
      ESC_HIGH = 3'b010,
      ESC_LOW  = 3'b100
   } esc_phase_type;

   // One accepted byte as the back end needs it: which results to produce,
   // and the fields of the primary result.
   typedef struct packed {
      logic [RES_COUNT-1:0] mask;
      logic [7:0]           data;
      logic                 has_byte;
      logic                 part;
      logic                 field_end;
   } fud_entry_type;

   function automatic logic [7:0] escape_digit(input logic [7:0] c);
      logic [7:0] ch;
      ch = (c == CHAR_PLUS) ? CHAR_SPACE : c;
      if (ch >= CHAR_UPPER_A) begin
         return (ch & CASE_MASK) - CHAR_UPPER_A + LETTER_BASE;
      end
      return ch - CHAR_ZERO;
   endfunction

endpackage

[rtl/form_urlencoded_decoder.sv]
// Top level of the streaming form body decoder.
// Instantiates fud_front, fud_queue and fud_back; uses fud_pkg.
//
// Usage: the encoded body enters on the req_ channel, one byte per
// transaction, with req_end_of_body set on the final byte. Decoded output
// leaves on the rsp_ channel, one result per transaction: a decoded byte
// (rsp_has_byte set) or a field end (rsp_field_end set), tagged with the
// field it belongs to (rsp_part, name or value). rsp_last_in_run marks the
// final result produced by one input byte; a '%' or the first escape digit
// produces no result at all unless it carries the end of the body.
// The first result of a byte passes through the queue, the back end's work
// register and the output register. The back end issues one result per cycle
// while rsp_ready is high, so an ordinary byte then sustains one transaction
// per cycle on both channels; a byte carrying the end of the body yields one
// to three results and holds the back end until the last of them is loaded.
// The front end classifies bytes into a short queue, so it keeps accepting
// while the receiver stalls until the queue fills, at which point req_ready
// falls. Results are never lost or repeated while rsp_ready is low.
// Reset (synchronous, active high) empties the queue and the output
// register and returns the parser to the start of a name.
module form_urlencoded_decoder
   import fud_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_body,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_part,
   output logic       rsp_field_end,
   output logic       rsp_last_in_run
);

   fud_entry_type push_entry;
   fud_entry_type head_entry;
   logic          push;
   logic          pop;
   logic          queue_empty;
   logic          queue_full;

   // Front end: state tracking and classification of each byte.
   fud_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_end_of_body (req_end_of_body),
      .queue_full      (queue_full),
      .push            (push),
      .push_entry      (push_entry)
   );

   // Decoupling queue: bytes that produce no result are never written.
   fud_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   // Back end: expansion into individual results and the output register.
   fud_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_entry      (head_entry),
      .queue_empty     (queue_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_part        (rsp_part),
      .rsp_field_end   (rsp_field_end),
      .rsp_last_in_run (rsp_last_in_run)
   );

endmodule

[rtl/fud_front.sv]
// Front end of the form decoder: accepts raw bytes, tracks name/value and
// escape state, and classifies each byte into a queue entry. Uses fud_pkg.
module fud_front
   import fud_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_in_byte,
   input  logic          req_end_of_body,
   input  logic          queue_full,
   output logic          push,
   output fud_entry_type push_entry
);

   logic          in_value_ff, in_value_in;
   esc_phase_type esc_ff, esc_in;
   logic [3:0]    high_nibble_ff, high_nibble_in;
   logic          accept;
   logic [7:0]    digit;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign digit     = escape_digit(req_in_byte);

   always_comb begin
      push_entry     = '0;
      in_value_in    = in_value_ff;
      esc_in         = esc_ff;
      high_nibble_in = high_nibble_ff;

      // Field separators win over any escape in progress.
      if (!in_value_ff && req_in_byte == CHAR_EQUALS) begin
         push_entry.mask[RES_PRIMARY] = 1'b1;
         push_entry.part              = PART_NAME;
         push_entry.field_end         = 1'b1;
         in_value_in                  = 1'b1;
         esc_in                       = ESC_NONE;
      end else if (in_value_ff && req_in_byte == CHAR_AMP) begin
         push_entry.mask[RES_PRIMARY] = 1'b1;
         push_entry.part              = PART_VALUE;
         push_entry.field_end         = 1'b1;
         in_value_in                  = 1'b0;
         esc_in                       = ESC_NONE;
      end else begin
         case (esc_ff)
            ESC_HIGH: begin
               high_nibble_in = digit[3:0];
               esc_in         = ESC_LOW;
            end
            ESC_LOW: begin
               push_entry.mask[RES_PRIMARY] = 1'b1;
               push_entry.data              = {high_nibble_ff, 4'h0} + digit;
               push_entry.has_byte          = 1'b1;
               push_entry.part              = in_value_ff;
               esc_in                       = ESC_NONE;
            end
            default: begin
               if (req_in_byte == CHAR_PERCENT) begin
                  esc_in = ESC_HIGH;
               end else begin
                  esc_in                       = ESC_NONE;
                  push_entry.mask[RES_PRIMARY] = 1'b1;
                  push_entry.data = (req_in_byte == CHAR_PLUS) ? CHAR_SPACE : req_in_byte;
                  push_entry.has_byte          = 1'b1;
                  push_entry.part              = in_value_ff;
               end
            end
         endcase
      end

      // End of body closes whatever is open and drops a partial escape.
      if (req_end_of_body) begin
         if (!in_value_in) begin
            push_entry.mask[RES_NAME_CLOSE] = 1'b1;
         end
         push_entry.mask[RES_VALUE_CLOSE] = 1'b1;
         in_value_in    = 1'b0;
         esc_in         = ESC_NONE;
         high_nibble_in = 4'h0;
      end
   end

   assign push = accept && (push_entry.mask != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_value_ff    <= 1'b0;
         esc_ff         <= ESC_NONE;
         high_nibble_ff <= 4'h0;
      end else if (accept) begin
         in_value_ff    <= in_value_in;
         esc_ff         <= esc_in;
         high_nibble_ff <= high_nibble_in;
      end
   end

endmodule

[rtl/fud_queue.sv]
// Short queue of classified entries between the front and back ends.
// Uses fud_pkg for the entry type.
module fud_queue
   import fud_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  fud_entry_type push_entry,
   input  logic          pop,
   output fud_entry_type head_entry,
   output logic          empty,
   output logic          full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   fud_entry_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == FULL_CNT);
   assign head_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue read while empty");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a lone write");

endmodule

[rtl/fud_back.sv]
// Back end of the form decoder: expands each queued entry into one to three
// results and holds them in the output register. Uses fud_pkg.
module fud_back
   import fud_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  fud_entry_type head_entry,
   input  logic          queue_empty,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    rsp_out_byte,
   output logic          rsp_has_byte,
   output logic          rsp_part,
   output logic          rsp_field_end,
   output logic          rsp_last_in_run
);

   logic                 work_valid_ff, work_valid_in;
   fud_entry_type        work_ff, work_in;
   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           out_byte_ff, out_byte_in;
   logic                 out_has_ff, out_has_in;
   logic                 out_part_ff, out_part_in;
   logic                 out_end_ff, out_end_in;
   logic                 out_last_ff, out_last_in;
   logic                 load_out;
   logic [RES_COUNT-1:0] mask_left;

   assign load_out = !out_valid_ff || rsp_ready;

   always_comb begin
      work_valid_in = work_valid_ff;
      work_in       = work_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_byte_in   = out_byte_ff;
      out_has_in    = out_has_ff;
      out_part_in   = out_part_ff;
      out_end_in    = out_end_ff;
      out_last_in   = out_last_ff;
      mask_left     = work_ff.mask;
      pop           = 1'b0;

      if (work_valid_ff && load_out) begin
         out_valid_in = 1'b1;
         if (work_ff.mask[RES_PRIMARY]) begin
            mask_left[RES_PRIMARY] = 1'b0;
            out_byte_in = work_ff.data;
            out_has_in  = work_ff.has_byte;
            out_part_in = work_ff.part;
            out_end_in  = work_ff.field_end;
         end else if (work_ff.mask[RES_NAME_CLOSE]) begin
            mask_left[RES_NAME_CLOSE] = 1'b0;
            out_byte_in = 8'h00;
            out_has_in  = 1'b0;
            out_part_in = PART_NAME;
            out_end_in  = 1'b1;
         end else begin
            mask_left[RES_VALUE_CLOSE] = 1'b0;
            out_byte_in = 8'h00;
            out_has_in  = 1'b0;
            out_part_in = PART_VALUE;
            out_end_in  = 1'b1;
         end
         out_last_in  = (mask_left == '0);
         work_in.mask = mask_left;
         if (mask_left == '0) begin
            // Refill from the queue in the same cycle the last result leaves.
            pop           = !queue_empty;
            work_valid_in = !queue_empty;
            work_in       = head_entry;
         end
      end else if (!work_valid_ff) begin
         pop           = !queue_empty;
         work_valid_in = !queue_empty;
         work_in       = head_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      out_byte_ff <= out_byte_in;
      out_has_ff  <= out_has_in;
      out_part_ff <= out_part_in;
      out_end_ff  <= out_end_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_has_byte    = out_has_ff;
   assign rsp_part        = out_part_ff;
   assign rsp_field_end   = out_end_ff;
   assign rsp_last_in_run = out_last_ff;

   a_work_has_results: assert property (@(posedge clock) disable iff (reset)
      work_valid_ff |-> work_ff.mask != '0)
      else $error("held entry has no results left");

   a_end_carries_no_byte: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_end_ff) |-> !out_has_ff)
      else $error("field end result carries a byte");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the form body decoder: a scoreboard class that predicts
// the decoded byte and field-end transactions, with paced drivers on both channels.
// Depends on fud_pkg and form_urlencoded_decoder.
module testbench;
   import fud_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Longest stretch without any transaction before the run is declared hung.
   localparam int HANG_LIMIT = 2000;
   // Bytes of random bodies to send after the directed part.
   localparam int RANDOM_BYTES = 460;
   // Cycles allowed after the last expected result before the verdict.
   localparam int SETTLE_CYCLES = 20;

   // One result transaction as the decoder should present it.
   typedef struct {
      logic [7:0] data;
      logic       has_byte;
      logic       part;
      logic       field_end;
      logic       last_in_run;
   } decoded_item_type;

   // Holds its own copy of the parser state and a queue of the results it
   // has worked out for every byte the decoder has accepted.
   class form_scoreboard;
      decoded_item_type decoded_due[$];
      logic          in_value;
      esc_phase_type esc_phase;
      logic [3:0]    high_nibble;
      int            errors;
      int            bytes_seen;
      int            bodies_seen;
      int            results_seen;

      function new();
         errors = 0;
         bytes_seen = 0;
         bodies_seen = 0;
         results_seen = 0;
         clear_parser();
      endfunction

      function void clear_parser();
         in_value = PART_NAME;
         esc_phase = ESC_NONE;
         high_nibble = 4'h0;
      endfunction

      // Weight of one escape digit, wrapped to eight bits with no check.
      // A plus sign counts as the space it stands for.
      function logic [7:0] digit_weight(input logic [7:0] c);
         logic [7:0] ch;
         logic [7:0] folded;
         ch = c;
         if (c == CHAR_PLUS) begin
            ch = CHAR_SPACE;
         end
         folded = ch;
         folded[5] = 1'b0;
         if (ch < CHAR_UPPER_A) begin
            return ch - CHAR_ZERO;
         end
         return folded - (CHAR_UPPER_A - LETTER_BASE);
      endfunction

      function void decode_byte(input logic [7:0] c, input logic eob);
         decoded_item_type run[$];
         decoded_item_type item;
         item.last_in_run = 1'b0;
         bytes_seen++;
         // The separators are tested first, so they cut an escape short.
         if (in_value == PART_NAME && c == CHAR_EQUALS) begin
            item.data = 8'h00; item.has_byte = 1'b0;
            item.part = PART_NAME; item.field_end = 1'b1;
            run.push_back(item);
            in_value = PART_VALUE;
            esc_phase = ESC_NONE;
         end else if (in_value == PART_VALUE && c == CHAR_AMP) begin
            item.data = 8'h00; item.has_byte = 1'b0;
            item.part = PART_VALUE; item.field_end = 1'b1;
            run.push_back(item);
            in_value = PART_NAME;
            esc_phase = ESC_NONE;
         end else if (esc_phase == ESC_HIGH) begin
            high_nibble = 4'(digit_weight(c));
            esc_phase = ESC_LOW;
         end else if (esc_phase == ESC_LOW) begin
            item.data = {high_nibble, 4'h0} + digit_weight(c);
            item.has_byte = 1'b1; item.part = in_value; item.field_end = 1'b0;
            run.push_back(item);
            esc_phase = ESC_NONE;
         end else if (c == CHAR_PERCENT) begin
            esc_phase = ESC_HIGH;
         end else begin
            item.data = (c == CHAR_PLUS) ? CHAR_SPACE : c;
            item.has_byte = 1'b1; item.part = in_value; item.field_end = 1'b0;
            run.push_back(item);
         end
         // The end of the body closes whatever is open; a bare name gets
         // an empty value after it.
         if (eob) begin
            item.data = 8'h00; item.has_byte = 1'b0; item.field_end = 1'b1;
            if (in_value == PART_NAME) begin
               item.part = PART_NAME;
               run.push_back(item);
            end
            item.part = PART_VALUE;
            run.push_back(item);
            clear_parser();
            bodies_seen++;
         end
         foreach (run[i]) begin
            item = run[i];
            item.last_in_run = (i == run.size() - 1);
            decoded_due.push_back(item);
         end
      endfunction

      function void report(input string field, input logic [7:0] want,
                           input logic [7:0] got);
         $display("%0t ns: %s expected %0h, actual %0h", $time, field, want, got);
         errors++;
      endfunction

      function void check_result(input logic [7:0] data, input logic has_byte,
                                 input logic part, input logic field_end,
                                 input logic last_in_run);
         decoded_item_type want;
         results_seen++;
         if (decoded_due.size() == 0) begin
            $display("%0t ns: result expected none, actual byte %0h has %0b part %0b end %0b",
                     $time, data, has_byte, part, field_end);
            errors++;
            return;
         end
         want = decoded_due.pop_front();
         if (data !== want.data) report("out_byte", want.data, data);
         if (has_byte !== want.has_byte)
            report("has_byte", 8'(want.has_byte), 8'(has_byte));
         if (part !== want.part) report("part", 8'(want.part), 8'(part));
         if (field_end !== want.field_end)
            report("field_end", 8'(want.field_end), 8'(field_end));
         if (last_in_run !== want.last_in_run)
            report("last_in_run", 8'(want.last_in_run), 8'(last_in_run));
      endfunction
   endclass

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_body = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_byte;
   logic       rsp_part;
   logic       rsp_field_end;
   logic       rsp_last_in_run;

   form_scoreboard board = new();

   // Sender pacing: bytes go out in bursts, most of them after an idle gap.
   int burst_left = 0;
   // Receiver pacing: the ready pattern changes mode every so often.
   typedef enum int {RX_STREAM, RX_COIN, RX_BURSTY, RX_RHYTHM} rx_mode_type;
   rx_mode_type rx_mode = RX_STREAM;
   int         rx_mode_left = 0;
   int         rx_hold = 0;
   logic [7:0] rx_rhythm = 8'hFF;
   int         rx_tick = 0;
   // Cycles since the last transaction on either channel.
   int         quiet_cycles = 0;
   // Bytes of the body currently being built.
   logic [7:0] body_q[$];

   form_urlencoded_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_end_of_body (req_end_of_body),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_part        (rsp_part),
      .rsp_field_end   (rsp_field_end),
      .rsp_last_in_run (rsp_last_in_run)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Both channels are sampled at the rising edge, where every input has
   // settled from the nonblocking drives of the previous edge. An accepted
   // request transaction is handed to the predictor before any result of
   // the same edge is checked; a result cannot come from a byte accepted at
   // the same edge anyway, since the decoder registers each byte first.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.decode_byte(req_in_byte, req_end_of_body);
         end
         if (rsp_valid && rsp_ready) begin
            board.check_result(rsp_out_byte, rsp_has_byte, rsp_part,
                               rsp_field_end, rsp_last_in_run);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
   end

   // The receiver switches between full speed, coin tosses, long stalls
   // and a repeating rhythm, so that back-pressure lands on every phase of
   // the decoder's work, including the multi-result end of a body.
   always @(posedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_mode_left = $urandom_range(20, 200);
         rx_rhythm = 8'($urandom) | 8'h01;
      end
      rx_mode_left--;
      rx_tick++;
      case (rx_mode)
         RX_STREAM: begin
            rsp_ready <= 1'b1;
         end
         RX_COIN: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         RX_BURSTY: begin
            if (rx_hold > 0) begin
               rx_hold--;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
               rx_hold = $urandom_range(3, 20);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
         default: begin
            rsp_ready <= rx_rhythm[rx_tick % 8];
         end
      endcase
   end

   // The run ends here if neither channel has moved for too long.
   initial begin
      while (quiet_cycles < HANG_LIMIT) @(posedge clock);
      $display("%0t ns: no transaction for %0d cycles, %0d results still awaited",
               $time, HANG_LIMIT, board.decoded_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Presents one byte and waits for its transaction. At the start of a
   // burst the sender may first drop valid for a random gap, with junk on
   // the payload lines, which the decoder must ignore.
   task automatic send_paced(input logic [7:0] data, input logic eob);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            req_in_byte <= 8'($urandom);
            req_end_of_body <= 1'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_in_byte <= data;
      req_end_of_body <= eob;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_text(input string text, input logic eob_on_last);
      for (int i = 0; i < text.len(); i++) begin
         send_paced(text[i], eob_on_last && (i == text.len() - 1));
      end
   endtask

   function automatic logic [7:0] any_hex_digit();
      string digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(0, 21)];
   endfunction

   // One piece of field content: mostly plain characters, plus signs and
   // well-formed escapes, with some escapes of arbitrary bytes (which may
   // hold a separator and so split the field early), the separator that is
   // literal on this side, and raw bytes of any value.
   function automatic void push_token(input logic value_side);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         body_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
      end else if (pick < 40) begin
         body_q.push_back(8'($urandom_range(CHAR_ZERO, CHAR_ZERO + 9)));
      end else if (pick < 55) begin
         body_q.push_back(CHAR_PLUS);
      end else if (pick < 80) begin
         body_q.push_back(CHAR_PERCENT);
         body_q.push_back(any_hex_digit());
         body_q.push_back(any_hex_digit());
      end else if (pick < 88) begin
         body_q.push_back(CHAR_PERCENT);
         body_q.push_back(8'($urandom));
         body_q.push_back(8'($urandom));
      end else if (pick < 94) begin
         body_q.push_back(value_side ? CHAR_EQUALS : CHAR_AMP);
      end else begin
         body_q.push_back(8'($urandom));
      end
   endfunction

   // Builds one body: usually a few name=value pairs with random content,
   // now and then a missing '=', a trailing '&' or an escape cut short by
   // the end of the body, and about one body in ten of pure noise.
   function automatic void build_body();
      int pairs;
      int noise_len;
      body_q.delete();
      if ($urandom_range(0, 9) == 0) begin
         noise_len = $urandom_range(1, 8);
         repeat (noise_len) body_q.push_back(8'($urandom));
         return;
      end
      pairs = $urandom_range(1, 4);
      for (int p = 0; p < pairs; p++) begin
         repeat ($urandom_range(0, 5)) push_token(PART_NAME);
         if ($urandom_range(0, 9) != 0) begin
            body_q.push_back(CHAR_EQUALS);
            repeat ($urandom_range(0, 5)) push_token(PART_VALUE);
         end
         if (p != pairs - 1 || $urandom_range(0, 6) == 0) begin
            body_q.push_back(CHAR_AMP);
         end
      end
      case ($urandom_range(0, 11))
         0: begin
            body_q.push_back(CHAR_PERCENT);
         end
         1: begin
            body_q.push_back(CHAR_PERCENT);
            body_q.push_back(any_hex_digit());
         end
         default: begin
         end
      endcase
      if (body_q.size() == 0) begin
         body_q.push_back(8'h71);
      end
   endfunction

   initial begin
      int random_bytes;
      random_bytes = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The name carries the zero byte, the top byte, a plus
      // sign, a literal '&' and an upper-case escape before the '='.
      send_paced(8'h00, 1'b0);
      send_paced(8'hFF, 1'b0);
      send_text("+&%41=", 1'b0);
      // In the value: a literal '=', a lower-case escape, a plus sign used
      // as an escape digit, and an escape cut short by the '&'.
      send_text("=%fF%+z%4&", 1'b0);
      // An escape in a name cut short by the '=', then a value closed by
      // the end of the body.
      send_text("%=x", 1'b1);
      // A name with no '=', which is given an empty value.
      send_text("n", 1'b1);
      // An empty pair closed by '&' on the last byte, which yields three results.
      send_text("=&", 1'b1);
      // An escape left open at the end of the body is dropped.
      send_text("%", 1'b1);

      while (random_bytes < RANDOM_BYTES) begin
         build_body();
         foreach (body_q[i]) begin
            send_paced(body_q[i], i == body_q.size() - 1);
         end
         random_bytes += body_q.size();
      end
      req_valid <= 1'b0;

      while (board.decoded_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (board.decoded_due.size() != 0) begin
         $display("%0t ns: %0d expected results never arrived",
                  $time, board.decoded_due.size());
         board.errors++;
      end
      $display("Decoded %0d bytes in %0d bodies, %0d result transactions checked.",
               board.bytes_seen, board.bodies_seen, board.results_seen);
      $display("Mismatches found: %0d.", board.errors);
      if (board.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
